FILE: src/ict_pkg.sv
`default_nettype none
package ict_pkg;
    localparam logic [1:0] FUNC_OBSERVE = 2'd0;
    localparam logic [1:0] FUNC_REAP    = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic [1:0] PH_DETECTING = 2'd0;
    localparam logic [1:0] PH_MATCHED   = 2'd1;
    localparam logic [1:0] PH_CONFIRMED = 2'd2;

    localparam logic [1:0] REG_UNKNOWN_AFTER = 2'd0;
    localparam logic [1:0] REG_CONFIRM_STREAK = 2'd1;
    localparam logic [1:0] REG_COOLDOWN = 2'd2;

    localparam logic [24:0] NO_RESIDENT = 25'h1FFFFFF;
    localparam logic signed [15:0] SIM_FLOOR = 16'sh8000;
    localparam logic [7:0] STREAK_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] key;
        logic [1:0]  phase;
        logic [24:0] resident;
        logic [7:0]  streak;
        logic signed [15:0] peak_sim;
        logic [31:0] first_seen;
        logic        unknown_sent;
    } t_session;
endpackage
`default_nettype wire

FILE: src/identity_confirmation_tracker_unit.sv
// identity confirmation tracker: keeps a session table of tracked subjects
// and a per-resident cooldown table. a transaction with func observation
// finds or creates its subject's session and may produce one report
// (unknown subject, or resident confirmed). func reap drops sessions not
// seen since the last reap or clear; func clear empties both tables.
// a single sequencer walks the tables one entry per cycle through one shared
// elapsed-time compare unit. after an observation is taken o_stall stays
// high through the search of all SESSION_SLOTS session entries and the
// update; a confirmation adds the cooldown search (look for the resident,
// then a free entry, then the oldest entry) and any report an emit state,
// and o_stall stays high longer while an earlier report is still
// stalled in the output register. reap, clear and the unused func code
// finish in the cycle they are taken and never raise o_stall. no new
// transaction is taken until the report, if any, has been handed to the
// output register. results wait in an output register with valid/stall.
// times wrap modulo 2^32.
`default_nettype none
module identity_confirmation_tracker_unit
    import ict_pkg::*;
#(
    parameter int SESSION_SLOTS  = 16,
    parameter int COOLDOWN_SLOTS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // configuration write port
    input  wire          i_cfg_we,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [31:0]  i_cfg_data,
    // input channel
    input  wire          i_valid,
    output logic         o_stall,
    input  wire  [1:0]   i_func,
    input  wire  [15:0]  i_subject_key,
    input  wire          i_has_match,
    input  wire  [23:0]  i_resident_id,
    input  wire signed [15:0] i_similarity,
    input  wire  [31:0]  i_timestamp_ms,
    // output channel
    output logic         o_valid,
    input  wire          i_stall,
    output logic [15:0]  o_out_subject_key,
    output logic         o_is_confirmed,
    output logic [23:0]  o_out_resident_id,
    output logic signed [15:0] o_best_similarity
);
    localparam int SW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
    localparam int CW = (COOLDOWN_SLOTS > 1) ? $clog2(COOLDOWN_SLOTS) : 1;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FIND   = 3'd1; // look for the subject's session
    localparam logic [2:0] ST_UPDATE = 3'd2; // update session, decide report
    localparam logic [2:0] ST_CLOOK  = 3'd3; // look for resident in cooldown table
    localparam logic [2:0] ST_CFREE  = 3'd4; // look for a free cooldown entry
    localparam logic [2:0] ST_COLD   = 3'd5; // find the oldest cooldown entry
    localparam logic [2:0] ST_EMIT   = 3'd6; // hand the report to the output

    // configuration
    logic [31:0] r_unknown_after, r_cooldown;
    logic [7:0]  r_confirm_streak;

    // session table: flags in flip-flops, payload in a memory
    logic [SESSION_SLOTS-1:0] r_slot_valid, r_slot_seen;
    t_session r_sess_mem [SESSION_SLOTS];
    // cooldown table
    logic [COOLDOWN_SLOTS-1:0] r_cool_valid;
    logic [23:0] r_cool_res  [COOLDOWN_SLOTS];
    logic [31:0] r_cool_time [COOLDOWN_SLOTS];

    logic [2:0]  r_state, n_state;
    logic [SW:0] r_sidx;
    logic [CW:0] r_cidx;
    // held transaction
    logic [15:0] r_key;
    logic        r_match;
    logic [23:0] r_rid;
    logic signed [15:0] r_sim;
    logic [31:0] r_now;
    // found session / free slot
    logic        r_found, r_free_ok;
    logic [SW-1:0] r_hit, r_free;
    // oldest cooldown search
    logic [CW-1:0] r_pick;
    logic [31:0] r_oldest;
    logic signed [15:0] r_rep_sim;
    logic        r_rep_conf;

    logic [SW-1:0] sidx;
    logic [CW-1:0] cidx;
    assign sidx = r_sidx[SW-1:0];
    assign cidx = r_cidx[CW-1:0];

    // session written by the update: the hit, or the first free slot
    logic [SW-1:0] tgt;
    assign tgt = r_found ? r_hit : r_free;

    // shared compare unit: elapsed time against a limit
    logic [31:0] cu_age, cu_lim;
    logic        cu_ge;
    t_session    cur, upd;
    logic        cool_done;

    always_comb begin
        cur    = r_sess_mem[r_hit];
        cu_age = 32'd0;
        cu_lim = 32'd0;
        if (r_state == ST_UPDATE) begin
            cu_age = r_now - cur.first_seen;
            cu_lim = r_unknown_after;
        end else begin
            cu_age = r_now - r_cool_time[cidx];
            cu_lim = r_cooldown;
        end
        cu_ge = (cu_age >= cu_lim);
    end

    // session update for an observation
    logic upd_report_unk, upd_try_conf;
    always_comb begin
        upd = cur;
        upd_report_unk = 1'b0;
        upd_try_conf   = 1'b0;
        if (!r_found) begin
            upd.key = r_key;
            upd.phase = PH_DETECTING;
            upd.resident = NO_RESIDENT;
            upd.streak = 8'd0;
            upd.peak_sim = SIM_FLOOR;
            upd.first_seen = r_now;
            upd.unknown_sent = 1'b0;
        end
        if (!r_match) begin
            if (upd.phase != PH_DETECTING) begin
                upd.phase = PH_DETECTING;
                upd.resident = NO_RESIDENT;
                upd.streak = 8'd0;
                upd.peak_sim = SIM_FLOOR;
            end
            // a new session has zero elapsed time
            if (!upd.unknown_sent && (r_found ? cu_ge : (r_unknown_after == 32'd0))) begin
                upd.unknown_sent = 1'b1;
                upd_report_unk = 1'b1;
            end
        end else begin
            if (upd.resident == {1'b0, r_rid}) begin
                if (upd.streak != STREAK_MAX) upd.streak = upd.streak + 8'd1;
                if (r_sim > upd.peak_sim) upd.peak_sim = r_sim;
            end else begin
                upd.resident = {1'b0, r_rid};
                upd.streak = 8'd1;
                upd.peak_sim = r_sim;
            end
            if (upd.phase == PH_DETECTING) upd.phase = PH_MATCHED;
            if (upd.streak >= r_confirm_streak && upd.phase != PH_CONFIRMED) begin
                upd.phase = PH_CONFIRMED;
                upd_try_conf = 1'b1;
            end
        end
    end

    assign cool_done = (r_cidx == (CW+1)'(COOLDOWN_SLOTS - 1));
    assign o_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unknown_after  <= 32'd3000;
            r_confirm_streak <= 8'd3;
            r_cooldown       <= 32'd10000;
            r_slot_valid <= '0;
            r_slot_seen  <= '0;
            r_cool_valid <= '0;
            r_state <= ST_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_UNKNOWN_AFTER:  r_unknown_after  <= i_cfg_data;
                    REG_CONFIRM_STREAK: r_confirm_streak <= i_cfg_data[7:0];
                    REG_COOLDOWN:       r_cooldown       <= i_cfg_data;
                    default: ;
                endcase
            end
            // the emit state handles its own valid
            if (o_valid && !i_stall && r_state != ST_EMIT) o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_key <= i_subject_key;
                        r_match <= i_has_match;
                        r_rid <= i_resident_id;
                        r_sim <= i_similarity;
                        r_now <= i_timestamp_ms;
                        r_sidx <= '0;
                        r_found <= 1'b0;
                        r_free_ok <= 1'b0;
                        case (i_func)
                            FUNC_OBSERVE: r_state <= ST_FIND;
                            FUNC_REAP: begin
                                r_slot_valid <= r_slot_valid & r_slot_seen;
                                r_slot_seen <= '0;
                            end
                            FUNC_CLEAR: begin
                                r_slot_valid <= '0;
                                r_slot_seen <= '0;
                                r_cool_valid <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_FIND: begin
                    // one session entry per cycle, first hit and first free kept
                    if (!r_found && r_slot_valid[sidx] && r_sess_mem[sidx].key == r_key) begin
                        r_found <= 1'b1;
                        r_hit <= sidx;
                    end
                    if (!r_free_ok && !r_slot_valid[sidx]) begin
                        r_free_ok <= 1'b1;
                        r_free <= sidx;
                    end
                    if (r_sidx == (SW+1)'(SESSION_SLOTS - 1)) r_state <= ST_UPDATE;
                    r_sidx <= r_sidx + 1'b1;
                end
                ST_UPDATE: begin
                    if (!r_found && !r_free_ok) r_state <= ST_IDLE; // table full: drop
                    else begin
                        r_slot_valid[tgt] <= 1'b1;
                        r_slot_seen[tgt] <= 1'b1;
                        r_sess_mem[tgt] <= upd;
                        r_rep_sim <= upd.peak_sim;
                        r_cidx <= '0;
                        if (upd_report_unk) begin
                            r_rep_conf <= 1'b0;
                            r_state <= ST_EMIT;
                        end else if (upd_try_conf) begin
                            r_rep_conf <= 1'b1;
                            r_state <= ST_CLOOK;
                        end else r_state <= ST_IDLE;
                    end
                end
                ST_CLOOK: begin
                    // first entry of this resident decides cooldown
                    if (r_cool_valid[cidx] && r_cool_res[cidx] == r_rid) begin
                        if (!cu_ge) r_state <= ST_IDLE; // suppressed
                        else begin
                            r_cool_time[cidx] <= r_now;
                            r_state <= ST_EMIT;
                        end
                    end else if (cool_done) begin
                        r_cidx <= '0;
                        r_state <= ST_CFREE;
                    end else r_cidx <= r_cidx + 1'b1;
                end
                ST_CFREE: begin
                    if (!r_cool_valid[cidx]) begin
                        r_cool_valid[cidx] <= 1'b1;
                        r_cool_res[cidx] <= r_rid;
                        r_cool_time[cidx] <= r_now;
                        r_state <= ST_EMIT;
                    end else if (cool_done) begin
                        r_cidx <= '0;
                        r_pick <= '0;
                        r_oldest <= '0;
                        r_state <= ST_COLD;
                    end else r_cidx <= r_cidx + 1'b1;
                end
                ST_COLD: begin
                    // greatest elapsed time, lowest index on ties
                    if (r_cidx == '0 || cu_age > r_oldest) begin
                        r_oldest <= cu_age;
                        r_pick <= cidx;
                    end
                    if (cool_done) begin
                        if (r_cidx == '0 || cu_age > r_oldest) begin
                            r_cool_res[cidx] <= r_rid;
                            r_cool_time[cidx] <= r_now;
                        end else begin
                            r_cool_res[r_pick] <= r_rid;
                            r_cool_time[r_pick] <= r_now;
                        end
                        r_state <= ST_EMIT;
                    end else r_cidx <= r_cidx + 1'b1;
                end
                ST_EMIT: begin
                    if (!o_valid || !i_stall) begin
                        o_valid <= 1'b1;
                        o_out_subject_key <= r_key;
                        o_is_confirmed <= r_rep_conf;
                        o_out_resident_id <= r_rep_conf ? r_rid : 24'd0;
                        o_best_similarity <= r_rep_conf ? r_rep_sim : 16'sd0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: src/ict_checker.sv
`default_nettype none
module ict_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire        o_is_confirmed,
    input wire [23:0] o_out_resident_id,
    input wire [15:0] o_best_similarity,
    input wire [15:0] o_out_subject_key
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_subject_key))
        else $error("stalled result changed");
    a_unk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_confirmed |-> o_out_resident_id == 24'd0 &&
        o_best_similarity == 16'd0)
        else $error("unknown report carries resident data");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result without busy sequencer");
endmodule

bind identity_confirmation_tracker_unit ict_checker u_ict_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_is_confirmed(o_is_confirmed),
    .o_out_resident_id(o_out_resident_id), .o_best_similarity(o_best_similarity),
    .o_out_subject_key(o_out_subject_key)
);
`default_nettype wire

FILE: test/tb_identity_confirmation_tracker_unit.sv
`default_nettype none
module tb_identity_confirmation_tracker_unit;
    import ict_pkg::*;

    localparam int NSLOT = 16;
    localparam int NCOOL = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // report layout as it leaves the block
    typedef struct packed {
        logic [15:0] key;
        logic        confirmed;
        logic [23:0] resident;
        logic signed [15:0] sim;
    } t_report;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall_out;
    logic [1:0] func = '0;
    logic [15:0] in_key = '0;
    logic has_match = 1'b0;
    logic [23:0] in_rid = '0;
    logic signed [15:0] similarity = '0;
    logic [31:0] timestamp = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] out_key;
    logic out_confirmed;
    logic [23:0] out_resident;
    logic signed [15:0] out_sim;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    identity_confirmation_tracker_unit uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall_out),
        .i_func(func), .i_subject_key(in_key), .i_has_match(has_match),
        .i_resident_id(in_rid), .i_similarity(similarity),
        .i_timestamp_ms(timestamp),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_out_subject_key(out_key), .o_is_confirmed(out_confirmed),
        .o_out_resident_id(out_resident), .o_best_similarity(out_sim)
    );

    // tracker mirror state
    logic [31:0] unknown_after;
    logic [7:0]  streak_goal;
    logic [31:0] cooldown_window;
    logic        sess_valid [NSLOT];
    logic        sess_seen  [NSLOT];
    t_session    sess       [NSLOT];
    logic        cool_used  [NCOOL];
    logic [23:0] cool_rid   [NCOOL];
    logic [31:0] cool_stamp [NCOOL];

    t_report pending_reports[$];
    int errors = 0;
    int idle_cycles = 0;
    int out_wait = 0;
    logic [31:0] clock_ms = 32'd0;

    function automatic void mirror_reset();
        unknown_after = 32'd3000;
        streak_goal = 8'd3;
        cooldown_window = 32'd10000;
        for (int i = 0; i < NSLOT; i++) begin
            sess_valid[i] = 1'b0;
            sess_seen[i] = 1'b0;
            sess[i] = '0;
        end
        for (int i = 0; i < NCOOL; i++) begin
            cool_used[i] = 1'b0;
            cool_rid[i] = '0;
            cool_stamp[i] = '0;
        end
    endfunction

    // a resident is muted while its last report is younger than the window
    function automatic bit resident_muted(logic [23:0] rid, logic [31:0] now);
        for (int i = 0; i < NCOOL; i++)
            if (cool_used[i] && cool_rid[i] == rid)
                return (now - cool_stamp[i]) < cooldown_window;
        return 1'b0;
    endfunction

    function automatic void stamp_cooldown(logic [23:0] rid, logic [31:0] now);
        int pick;
        logic [31:0] oldest;
        logic [31:0] age;
        pick = -1;
        for (int i = 0; i < NCOOL; i++)
            if (cool_used[i] && cool_rid[i] == rid) begin
                cool_stamp[i] = now;
                return;
            end
        for (int i = 0; i < NCOOL; i++)
            if (!cool_used[i] && pick < 0) pick = i;
        if (pick < 0) begin
            // evict the entry that has waited longest, lowest index on ties
            pick = 0;
            oldest = now - cool_stamp[0];
            for (int i = 1; i < NCOOL; i++) begin
                age = now - cool_stamp[i];
                if (age > oldest) begin
                    oldest = age;
                    pick = i;
                end
            end
        end
        cool_used[pick] = 1'b1;
        cool_rid[pick] = rid;
        cool_stamp[pick] = now;
    endfunction

    // advance the mirror by one transaction and queue its report, if any
    function automatic void track_transaction(logic [1:0] f, logic [15:0] key, logic m,
                                              logic [23:0] rid, logic signed [15:0] sim,
                                              logic [31:0] now);
        int s;
        t_report r;
        s = -1;
        if (f == FUNC_REAP) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (sess_valid[i] && !sess_seen[i]) sess_valid[i] = 1'b0;
                sess_seen[i] = 1'b0;
            end
            return;
        end
        if (f == FUNC_CLEAR) begin
            for (int i = 0; i < NSLOT; i++) begin
                sess_valid[i] = 1'b0;
                sess_seen[i] = 1'b0;
            end
            for (int i = 0; i < NCOOL; i++) cool_used[i] = 1'b0;
            return;
        end
        if (f != FUNC_OBSERVE) return;
        for (int i = 0; i < NSLOT; i++)
            if (s < 0 && sess_valid[i] && sess[i].key == key) s = i;
        if (s < 0) begin
            for (int i = 0; i < NSLOT; i++)
                if (s < 0 && !sess_valid[i]) s = i;
            if (s < 0) return;  // table full, new subject dropped
            sess_valid[s] = 1'b1;
            sess[s].key = key;
            sess[s].phase = PH_DETECTING;
            sess[s].resident = NO_RESIDENT;
            sess[s].streak = '0;
            sess[s].peak_sim = SIM_FLOOR;
            sess[s].first_seen = now;
            sess[s].unknown_sent = 1'b0;
        end
        sess_seen[s] = 1'b1;
        if (!m) begin
            if (sess[s].phase != PH_DETECTING) begin
                sess[s].phase = PH_DETECTING;
                sess[s].resident = NO_RESIDENT;
                sess[s].streak = '0;
                sess[s].peak_sim = SIM_FLOOR;
            end
            if (!sess[s].unknown_sent && (now - sess[s].first_seen) >= unknown_after) begin
                sess[s].unknown_sent = 1'b1;
                r = '{key: key, confirmed: 1'b0, resident: '0, sim: '0};
                pending_reports = {pending_reports, r};
            end
            return;
        end
        if (sess[s].resident == {1'b0, rid}) begin
            if (sess[s].streak != STREAK_MAX) sess[s].streak++;
            if (sim > sess[s].peak_sim) sess[s].peak_sim = sim;
        end else begin
            sess[s].resident = {1'b0, rid};
            sess[s].streak = 8'd1;
            sess[s].peak_sim = sim;
        end
        if (sess[s].phase == PH_DETECTING) sess[s].phase = PH_MATCHED;
        if (sess[s].streak >= streak_goal && sess[s].phase != PH_CONFIRMED) begin
            sess[s].phase = PH_CONFIRMED;
            if (!resident_muted(rid, now)) begin
                stamp_cooldown(rid, now);
                r = '{key: key, confirmed: 1'b1, resident: rid, sim: sess[s].peak_sim};
                pending_reports = {pending_reports, r};
            end
        end
    endfunction

    // result side: after each accepted report stall for a drawn count of cycles
    always @(posedge clk) begin
        t_report want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_wait = 0;
        end else begin
            if (out_valid && !out_stall) begin
                if (pending_reports.size() == 0) begin
                    $error("report with nothing expected: key %h", out_key);
                    errors++;
                end else begin
                    want = pending_reports.pop_front();
                    if (out_key !== want.key) begin
                        $error("out_subject_key exp %h got %h", want.key, out_key);
                        errors++;
                    end
                    if (out_confirmed !== want.confirmed) begin
                        $error("is_confirmed exp %b got %b", want.confirmed, out_confirmed);
                        errors++;
                    end
                    if (out_resident !== want.resident) begin
                        $error("out_resident_id exp %h got %h", want.resident, out_resident);
                        errors++;
                    end
                    if (out_sim !== want.sim) begin
                        $error("best_similarity exp %0d got %0d", want.sim, out_sim);
                        errors++;
                    end
                end
                out_wait = $urandom_range(0, 5);
            end
            if (out_wait > 0) begin
                out_stall <= 1'b1;
                out_wait--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no accepted transaction either side
    always @(posedge clk) begin
        if ((in_valid && !in_stall_out) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    bit sender_gaps = 1'b1;

    // valid stays up after acceptance until the next item or an idle gap replaces it
    task automatic send_item(logic [1:0] f, logic [15:0] key, logic m, logic [23:0] rid,
                             logic signed [15:0] sim, logic [31:0] now);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        in_key <= key;
        has_match <= m;
        in_rid <= rid;
        similarity <= sim;
        timestamp <= now;
        @(posedge clk);
        while (in_stall_out) @(posedge clk);
        track_transaction(f, key, m, rid, sim, now);
    endtask

    task automatic observe(logic [15:0] key, logic m, logic [23:0] rid,
                           logic signed [15:0] sim, logic [31:0] now);
        send_item(FUNC_OBSERVE, key, m, rid, sim, now);
    endtask

    localparam int SESSION_SLOTS_LAT = NSLOT + 3 * NCOOL + 20;

    // results drain, then let a full observation scan finish
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SESSION_SLOTS_LAT) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_UNKNOWN_AFTER) unknown_after = val;
        else if (idx == REG_CONFIRM_STREAK) streak_goal = val[7:0];
        else if (idx == REG_COOLDOWN) cooldown_window = val;
    endtask

    task automatic test_directed();
        send_item(FUNC_CLEAR, 16'h0, 1'b0, 24'h0, 16'sh0, clock_ms);
        // unknown after the reset window, reported once only
        observe(16'h0000, 1'b0, 24'h0, 16'sh0, 32'd0);
        observe(16'h0000, 1'b0, 24'hFFFFFF, 16'sh7FFF, 32'd3000);
        observe(16'h0000, 1'b0, 24'h0, 16'sh0, 32'd9000);
        // confirmation after three matches, best similarity kept
        observe(16'hFFFF, 1'b1, 24'hFFFFFF, 16'sh8000, 32'd10);
        observe(16'hFFFF, 1'b1, 24'hFFFFFF, 16'sh7FFF, 32'd20);
        observe(16'hFFFF, 1'b1, 24'hFFFFFF, 16'sh0001, 32'd30);
        // different resident restarts streak, confirmed does not re-confirm
        observe(16'hFFFF, 1'b1, 24'h000001, 16'sh1234, 32'd40);
        observe(16'hFFFF, 1'b1, 24'h000001, 16'sh1234, 32'd50);
        observe(16'hFFFF, 1'b1, 24'h000001, 16'sh1234, 32'd60);
        // no match drops back to detecting, then cooldown mutes same resident
        observe(16'hFFFF, 1'b0, 24'h0, 16'sh0, 32'd70);
        for (int i = 0; i < 3; i++) observe(16'hFFFF, 1'b1, 24'hFFFFFF, 16'sh100, 32'd80 + i);
        // unused func code does nothing
        send_item(FUNC_UNUSED, 16'hFFFF, 1'b1, 24'hFFFFFF, 16'sh7FFF, 32'hFFFFFFFF);
        // frame end reaps the unseen session
        send_item(FUNC_REAP, 16'h0, 1'b0, 24'h0, 16'sh0, 32'd0);
        observe(16'h0000, 1'b0, 24'h0, 16'sh0, 32'd100);
        send_item(FUNC_REAP, 16'h0, 1'b0, 24'h0, 16'sh0, 32'd0);
        // time wrap on the unknown check
        observe(16'h00AA, 1'b0, 24'h0, 16'sh0, 32'hFFFFFF00);
        observe(16'h00AA, 1'b0, 24'h0, 16'sh0, 32'd3000);
        // fill the table so a new subject is dropped
        for (int i = 0; i < NSLOT + 1; i++)
            observe(16'h1000 + i[15:0], 1'b0, 24'h0, 16'sh0, 32'd5000);
        send_item(FUNC_CLEAR, 16'h0, 1'b0, 24'h0, 16'sh0, 32'd0);
    endtask

    task automatic test_config_extremes();
        write_reg(REG_UNKNOWN_AFTER, 32'd0);
        write_reg(REG_CONFIRM_STREAK, 32'd1);
        write_reg(REG_COOLDOWN, 32'd0);
        observe(16'h0042, 1'b0, 24'h0, 16'sh0, 32'd1);
        observe(16'h0043, 1'b1, 24'h000777, -16'sd5, 32'd1);
        observe(16'h0044, 1'b1, 24'h000777, 16'sd5, 32'd1);
        write_reg(REG_UNKNOWN_AFTER, 32'hFFFFFFFF);
        write_reg(REG_CONFIRM_STREAK, 32'd255);
        write_reg(REG_COOLDOWN, 32'hFFFFFFFF);
        for (int i = 0; i < 258; i++)
            observe(16'h0050, 1'b1, 24'h00ABCD, 16'($urandom), 32'd2 + i);
        observe(16'h0051, 1'b0, 24'h0, 16'sh0, 32'd0);
        observe(16'h0051, 1'b0, 24'h0, 16'sh0, 32'hFFFFFFFF);
        send_item(FUNC_CLEAR, 16'h0, 1'b0, 24'h0, 16'sh0, 32'd0);
    endtask

    // many residents confirmed, more than the cooldown table holds, forcing evictions
    task automatic test_cooldown_eviction();
        write_reg(REG_CONFIRM_STREAK, 32'd1);
        write_reg(REG_COOLDOWN, 32'd50);
        for (int i = 0; i < 40; i++) begin
            observe(16'h2000 + i[15:0], 1'b1, 24'(24'h300 + $urandom_range(0, 20)),
                    16'($urandom), 32'd1000 + $urandom_range(0, 200));
            if (i % 8 == 7) send_item(FUNC_REAP, 16'h0, 1'b0, 24'h0, 16'sh0, 32'd0);
        end
        send_item(FUNC_CLEAR, 16'h0, 1'b0, 24'h0, 16'sh0, 32'd0);
    endtask

    // frames of plausible tracking: few subjects, few residents, rising time
    task automatic test_random_frames(int n_items);
        int sent;
        int fr;
        logic [15:0] key;
        logic [23:0] rid;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 29) == 0) begin
                write_reg(REG_UNKNOWN_AFTER, $urandom_range(0, 3) * 400);
                write_reg(REG_CONFIRM_STREAK, $urandom_range(1, 4));
                write_reg(REG_COOLDOWN, $urandom_range(0, 3) * 300);
            end
            if (sent > n_items / 2 && sent < n_items / 2 + 20) begin
                // stretch with no sender gaps, right after the full drain
                sender_gaps = 1'b0;
            end else begin
                sender_gaps = 1'b1;
            end
            clock_ms += $urandom_range(0, 1) ? 32'd100 : $urandom_range(0, 400);
            fr = $urandom_range(1, 6);
            for (int j = 0; j < fr; j++) begin
                if ($urandom_range(0, 19) == 0) begin
                    // noise: arbitrary content
                    send_item(2'($urandom_range(0, 3)), 16'($urandom), 1'($urandom),
                              24'($urandom), 16'($urandom), $urandom);
                end else begin
                    key = $urandom_range(0, 1) ? 16'($urandom_range(0, 20)) : 16'($urandom);
                    rid = $urandom_range(0, 3) != 0 ? 24'($urandom_range(0, 5)) : 24'($urandom);
                    observe(key, $urandom_range(0, 3) != 0, rid, 16'($urandom), clock_ms);
                end
                sent++;
            end
            send_item(($urandom_range(0, 40) == 0) ? FUNC_CLEAR : FUNC_REAP, 16'($urandom),
                      1'($urandom), 24'($urandom), 16'($urandom), $urandom);
            sent++;
            if (sent == n_items / 2) wait_drained();
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        mirror_reset();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_cooldown_eviction();
        test_random_frames(1000);
        wait_drained();
        if (errors == 0 && pending_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
